>>> design/bfrs_pkg.sv
`default_nettype none
package bfrs_pkg;

	localparam int SAMPLE_W = 8;   // row sample and average width
	localparam int CFG_W    = 6;   // kernel_size register width
	localparam int QUOT_W   = 8;   // quotient bits produced by the divider

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0]    kcfg_t;

endpackage
`default_nettype wire

>>> design/bfrs_in_if.sv
`default_nettype none
interface bfrs_in_if
	import bfrs_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface
`default_nettype wire

>>> design/bfrs_out_if.sv
`default_nettype none
interface bfrs_out_if
	import bfrs_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t smoothed_value;
	logic    run_end;
	logic    row_too_short;

	modport source (output valid, output smoothed_value, output run_end,
		output row_too_short, input ready);
	modport sink   (input valid, input smoothed_value, input run_end,
		input row_too_short, output ready);
endinterface
`default_nettype wire

>>> design/bfrs_cfg_if.sv
`default_nettype none
interface bfrs_cfg_if
	import bfrs_pkg::*;
();
	logic  valid;
	logic  ready;
	kcfg_t kernel_size;

	modport source (output valid, output kernel_size, input ready);
	modport sink   (input valid, input kernel_size, output ready);
endinterface
`default_nettype wire

>>> design/box_filter_row_smoother_top.sv
// A sample transaction is taken in idle, the window is updated in S_UPD, and the
// single restoring divider then forms the quotient in S_DIV before S_EMIT offers it.
// No new sample is taken until every result of the last one has been sent; a
// fill-only sample goes back to idle from S_UPD, a short row end goes straight to S_EMIT.
// Reset (arst_n low, asynchronous): kernel_size back to 3, row sum, fill count and
// ring pointer cleared; the sample ring itself is not cleared and holds no valid bits.
`default_nettype none
module box_filter_row_smoother_top
	import bfrs_pkg::*;
#(
	parameter int MAX_WINDOW = 63
) (
	input  wire           clk,
	input  wire           arst_n,
	bfrs_in_if.sink       row_in,
	bfrs_out_if.source    avg_out,
	bfrs_cfg_if.sink      cfg
);

	// Largest usable window: clamped to 3..63, then made odd.
	localparam int LIM_C  = (MAX_WINDOW > 63) ? 63 : ((MAX_WINDOW < 3) ? 3 : MAX_WINDOW);
	localparam int LIM    = LIM_C - 1 + (LIM_C % 2);
	localparam int K_W    = $clog2(LIM + 1);          // holds the window length itself
	localparam int PTR_W  = $clog2(MAX_WINDOW);       // ring index
	localparam int SUM_W  = SAMPLE_W + $clog2(LIM + 1);
	localparam int STEP_W = $clog2(QUOT_W);

	// Sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [K_W-1:0]    win_len_q;     // effective odd window length K
	logic [SUM_W-1:0]  sum_q;
	logic [K_W-1:0]    seen_q;        // fill count, saturates at K
	logic [PTR_W-1:0]  ptr_q;

	sample_t           smp_q;
	logic              last_q;
	sample_t           rd_q;          // ring entry about to be replaced

	logic [SUM_W-1:0]  rem_q;         // divider remainder
	logic [SUM_W-1:0]  dvs_q;         // divider, K shifted into place
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic [K_W-1:0]    reps_q;        // results still to send
	logic              err_q;

	sample_t           ring_mem [MAX_WINDOW];

	// kernel_size -> K: small values act as 2, even values go up by one,
	// then clamp to the largest odd window.
	kcfg_t             k_raw;
	kcfg_t             k_odd;
	logic [K_W-1:0]    k_new;

	always_comb begin
		k_raw = (cfg.kernel_size < kcfg_t'(2)) ? kcfg_t'(2) : cfg.kernel_size;
		k_odd = k_raw | kcfg_t'(1);
		if (k_odd > kcfg_t'(LIM)) begin
			k_new = K_W'(LIM);
		end else begin
			k_new = K_W'(k_odd);
		end
	end

	// Handshakes: configuration has priority while idle.
	logic in_acc;
	logic cfg_acc;
	logic out_acc;

	assign cfg.ready    = (state_q == S_IDLE);
	assign row_in.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg_acc      = cfg.valid && cfg.ready;
	assign in_acc       = row_in.valid && row_in.ready;
	assign out_acc      = avg_out.valid && avg_out.ready;

	// Error result carries a zero average (quotient cleared in S_UPD).
	assign avg_out.valid          = (state_q == S_EMIT);
	assign avg_out.smoothed_value = sample_t'(quot_q);
	assign avg_out.run_end        = (reps_q == K_W'(1));
	assign avg_out.row_too_short  = err_q;

	// Window update, evaluated in S_UPD.
	logic             full_before;
	logic [K_W-1:0]   seen_n;
	logic             filled;
	logic [SUM_W-1:0] sum_n;
	logic [K_W-1:0]   ptr_inc;
	logic [PTR_W-1:0] ptr_n;
	logic [K_W-1:0]   half_k;
	logic [K_W-1:0]   reps_n;

	always_comb begin
		full_before = (seen_q == win_len_q);
		seen_n      = full_before ? seen_q : seen_q + K_W'(1);
		filled      = (seen_n == win_len_q);
		if (full_before) begin
			sum_n = sum_q - SUM_W'(rd_q) + SUM_W'(smp_q);
		end else begin
			sum_n = sum_q + SUM_W'(smp_q);
		end
		ptr_inc = K_W'(ptr_q) + K_W'(1);
		ptr_n   = (ptr_inc >= win_len_q) ? '0 : PTR_W'(ptr_inc);
		half_k  = win_len_q >> 1;
		// first fill repeats the average K/2+1 times; a row end adds K/2 more
		reps_n  = (full_before ? K_W'(1) : half_k + K_W'(1)) + (last_q ? half_k : '0);
	end

	// Divider step: one quotient bit per cycle, quotient known to fit QUOT_W.
	logic             take;
	assign take = (rem_q >= dvs_q);

	// Sample ring: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			rd_q <= ring_mem[ptr_q];
		end
		if (state_q == S_UPD) begin
			ring_mem[ptr_q] <= smp_q;
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= row_in.sample;
			last_q <= row_in.last_sample;
		end
		case (state_q)
			S_UPD: begin
				rem_q  <= sum_n;
				dvs_q  <= SUM_W'(win_len_q) << (QUOT_W - 1);
				quot_q <= '0;
				step_q <= '0;
			end
			S_DIV: begin
				if (take) begin
					rem_q <= rem_q - dvs_q;
				end
				quot_q <= {quot_q[QUOT_W-2:0], take};
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Control state and row state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			win_len_q <= K_W'(3);
			sum_q     <= '0;
			seen_q    <= '0;
			ptr_q     <= '0;
			reps_q    <= '0;
			err_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						// any write restarts the row
						win_len_q <= k_new;
						sum_q     <= '0;
						seen_q    <= '0;
						ptr_q     <= '0;
					end else if (in_acc) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (last_q) begin
						sum_q  <= '0;
						seen_q <= '0;
						ptr_q  <= '0;
					end else begin
						sum_q  <= sum_n;
						seen_q <= seen_n;
						ptr_q  <= ptr_n;
					end
					if (filled) begin
						reps_q  <= reps_n;
						err_q   <= 1'b0;
						state_q <= S_DIV;
					end else if (last_q) begin
						// row ended before the window filled: one error result
						reps_q  <= K_W'(1);
						err_q   <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (step_q == STEP_W'(QUOT_W - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						reps_q <= reps_q - K_W'(1);
						if (reps_q == K_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
